FILE: design/gtsq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generation-tagged slot queue package
// Shared types and constants for the slot queue controller.
// ----------------------------------------------------------------------------
package gtsq_pkg;

  // Fixed widths of the request and result fields.
  localparam int unsigned GEN_FIELD_W = 30;
  localparam int unsigned IDX_FIELD_W = 8;
  localparam int unsigned CNT_W       = 9;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 30;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LAST_GEN = 2'd1;

  // Register reset values.
  localparam logic [CNT_W-1:0]       CAPACITY_RESET = 9'd256;
  localparam logic [GEN_FIELD_W-1:0] LAST_GEN_RESET = 30'd8388607;

  typedef enum logic [2:0] {
    KIND_RESERVE_PUSH = 3'd0,
    KIND_COMMIT_PUSH  = 3'd1,
    KIND_RESERVE_POP  = 3'd2,
    KIND_COMMIT_POP   = 3'd3,
    KIND_ABORT_PUSH   = 3'd4,
    KIND_CLEAR_POP    = 3'd5,
    KIND_DISABLE      = 3'd6,
    KIND_ENABLE       = 3'd7
  } kind_e;

  typedef enum logic [2:0] {
    STATUS_OK       = 3'd0,
    STATUS_FULL     = 3'd1,
    STATUS_EMPTY    = 3'd2,
    STATUS_DISABLED = 3'd3,
    STATUS_BUSY     = 3'd4,
    STATUS_END      = 3'd5,
    STATUS_MISMATCH = 3'd6
  } status_e;

  typedef enum logic [1:0] {
    SLOT_EMPTY   = 2'd0,
    SLOT_WRITING = 2'd1,
    SLOT_FULL    = 2'd2,
    SLOT_READING = 2'd3
  } slot_st_e;

  // Per-request outcome handed from the execute logic to the result register.
  typedef struct packed {
    status_e                  status;
    logic [GEN_FIELD_W-1:0]   ggen;
    logic [IDX_FIELD_W-1:0]   gidx;
  } res_t;

endpackage

FILE: design/gtsq_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module gtsq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                        wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: design/gtsq_exec.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Slot queue execute logic
// Decides one request from the slot entry and the pointer state.
// ----------------------------------------------------------------------------
module gtsq_exec #(
  parameter int unsigned DEPTH    = 256,
  parameter int unsigned GEN_BITS = 30
) (
  input  gtsq_pkg::kind_e                         kind_i,
  input  logic [gtsq_pkg::GEN_FIELD_W-1:0]        gen_i,
  input  logic [gtsq_pkg::IDX_FIELD_W-1:0]        idx_i,
  input  logic [GEN_BITS+1:0]                     entry_i,
  input  logic [GEN_BITS-1:0]                     push_gen_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] push_slot_i,
  input  logic [GEN_BITS-1:0]                     pop_gen_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] pop_slot_i,
  input  logic                                    disabled_i,
  input  logic [gtsq_pkg::CNT_W-1:0]              count_i,
  input  logic [gtsq_pkg::CNT_W-1:0]              eff_cap_i,
  input  logic [GEN_BITS-1:0]                     eff_last_i,
  output logic [GEN_BITS-1:0]                     push_gen_o,
  output logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] push_slot_o,
  output logic [GEN_BITS-1:0]                     pop_gen_o,
  output logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] pop_slot_o,
  output logic                                    disabled_o,
  output logic [gtsq_pkg::CNT_W-1:0]              count_o,
  output logic                                    we_o,
  output logic [GEN_BITS+1:0]                     wdata_o,
  output gtsq_pkg::res_t                          res_o
);
  import gtsq_pkg::*;

  localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CMP_W = (IDX_W + 1 > CNT_W) ? IDX_W + 1 : CNT_W;
  localparam int unsigned SEL_W = (IDX_W > IDX_FIELD_W) ? IDX_W : IDX_FIELD_W;

  function automatic logic [GEN_BITS-1:0] next_gen(input logic [GEN_BITS-1:0] g,
                                                   input logic [GEN_BITS-1:0] last);
    return (g >= last) ? '0 : g + GEN_BITS'(1);
  endfunction

  logic [GEN_BITS-1:0] eg;
  slot_st_e            es;
  logic [GEN_BITS-1:0] gin;
  logic                args_ok;
  logic                pop_at_req;
  logic [GEN_BITS-1:0] push_adv_gen, pop_adv_gen;
  logic [IDX_W-1:0]    push_adv_slot, pop_adv_slot;
  logic [CNT_W-1:0]    cnt_up, cnt_dec, cnt_down;

  assign eg  = entry_i[GEN_BITS+1:2];
  assign es  = slot_st_e'(entry_i[1:0]);
  assign gin = gen_i[GEN_BITS-1:0];

  assign args_ok    = (CMP_W'(idx_i) < CMP_W'(eff_cap_i)) &&
                      (gen_i <= GEN_FIELD_W'(eff_last_i));
  assign pop_at_req = (GEN_FIELD_W'(pop_gen_i) == gen_i) &&
                      (SEL_W'(pop_slot_i) == SEL_W'(idx_i));

  // Pointer advance: wrap the slot at capacity and step the generation.
  always_comb begin
    if (CMP_W'(push_slot_i) + CMP_W'(1) >= CMP_W'(eff_cap_i)) begin
      push_adv_slot = '0;
      push_adv_gen  = next_gen(push_gen_i, eff_last_i);
    end else begin
      push_adv_slot = push_slot_i + IDX_W'(1);
      push_adv_gen  = push_gen_i;
    end
    if (CMP_W'(pop_slot_i) + CMP_W'(1) >= CMP_W'(eff_cap_i)) begin
      pop_adv_slot = '0;
      pop_adv_gen  = next_gen(pop_gen_i, eff_last_i);
    end else begin
      pop_adv_slot = pop_slot_i + IDX_W'(1);
      pop_adv_gen  = pop_gen_i;
    end
  end

  // Occupancy saturates at zero and at the effective capacity.
  assign cnt_up   = (count_i < eff_cap_i) ? count_i + CNT_W'(1) : count_i;
  assign cnt_dec  = (count_i != '0) ? count_i - CNT_W'(1) : count_i;
  assign cnt_down = (cnt_dec > eff_cap_i) ? eff_cap_i : cnt_dec;

  always_comb begin
    push_gen_o   = push_gen_i;
    push_slot_o  = push_slot_i;
    pop_gen_o    = pop_gen_i;
    pop_slot_o   = pop_slot_i;
    disabled_o   = disabled_i;
    count_o      = count_i;
    we_o         = 1'b0;
    wdata_o      = entry_i;
    res_o.status = STATUS_OK;
    res_o.ggen   = '0;
    res_o.gidx   = '0;

    unique case (kind_i)
      KIND_RESERVE_PUSH: begin
        if (disabled_i) begin
          res_o.status = STATUS_DISABLED;
        end else if (entry_i == {push_gen_i, SLOT_EMPTY}) begin
          we_o        = 1'b1;
          wdata_o     = {push_gen_i, SLOT_WRITING};
          res_o.ggen  = GEN_FIELD_W'(push_gen_i);
          res_o.gidx  = IDX_FIELD_W'(push_slot_i);
          push_gen_o  = push_adv_gen;
          push_slot_o = push_adv_slot;
          count_o     = cnt_up;
        end else if (next_gen(eg, eff_last_i) == push_gen_i && eg != push_gen_i) begin
          res_o.status = (es == SLOT_READING) ? STATUS_BUSY : STATUS_FULL;
        end else begin
          push_gen_o   = push_adv_gen;
          push_slot_o  = push_adv_slot;
          count_o      = cnt_up;
          res_o.status = STATUS_BUSY;
        end
      end
      KIND_COMMIT_PUSH: begin
        if (!args_ok || entry_i != {gin, SLOT_WRITING}) begin
          res_o.status = STATUS_MISMATCH;
        end else begin
          we_o    = 1'b1;
          wdata_o = {gin, SLOT_FULL};
        end
      end
      KIND_COMMIT_POP: begin
        if (!args_ok || entry_i != {gin, SLOT_READING}) begin
          res_o.status = STATUS_MISMATCH;
        end else begin
          we_o    = 1'b1;
          wdata_o = {next_gen(gin, eff_last_i), SLOT_EMPTY};
        end
      end
      KIND_RESERVE_POP: begin
        if (entry_i == {pop_gen_i, SLOT_FULL}) begin
          we_o       = 1'b1;
          wdata_o    = {pop_gen_i, SLOT_READING};
          res_o.ggen = GEN_FIELD_W'(pop_gen_i);
          res_o.gidx = IDX_FIELD_W'(pop_slot_i);
          pop_gen_o  = pop_adv_gen;
          pop_slot_o = pop_adv_slot;
          count_o    = cnt_down;
        end else if (eg != pop_gen_i && next_gen(eg, eff_last_i) == pop_gen_i) begin
          res_o.status = STATUS_EMPTY;
        end else if (eg == pop_gen_i && es == SLOT_EMPTY) begin
          res_o.status = STATUS_EMPTY;
        end else if (eg != pop_gen_i || es == SLOT_WRITING) begin
          res_o.status = STATUS_BUSY;
        end else begin
          pop_gen_o    = pop_adv_gen;
          pop_slot_o   = pop_adv_slot;
          count_o      = cnt_down;
          res_o.status = STATUS_BUSY;
        end
      end
      KIND_ABORT_PUSH: begin
        if (!args_ok || entry_i != {gin, SLOT_WRITING} || !pop_at_req) begin
          res_o.status = STATUS_MISMATCH;
        end else begin
          we_o       = 1'b1;
          wdata_o    = {next_gen(gin, eff_last_i), SLOT_EMPTY};
          pop_gen_o  = pop_adv_gen;
          pop_slot_o = pop_adv_slot;
          count_o    = cnt_down;
        end
      end
      KIND_CLEAR_POP: begin
        if (!args_ok) begin
          res_o.status = STATUS_MISMATCH;
        end else if (pop_at_req) begin
          res_o.status = STATUS_END;
        end else if (entry_i == {pop_gen_i, SLOT_FULL}) begin
          we_o       = 1'b1;
          wdata_o    = {pop_gen_i, SLOT_READING};
          res_o.ggen = GEN_FIELD_W'(pop_gen_i);
          res_o.gidx = IDX_FIELD_W'(pop_slot_i);
          pop_gen_o  = pop_adv_gen;
          pop_slot_o = pop_adv_slot;
          count_o    = cnt_down;
        end else if (es == SLOT_WRITING || es == SLOT_FULL) begin
          res_o.status = STATUS_BUSY;
        end else begin
          pop_gen_o    = pop_adv_gen;
          pop_slot_o   = pop_adv_slot;
          count_o      = cnt_down;
          res_o.status = STATUS_BUSY;
        end
      end
      KIND_DISABLE: begin
        disabled_o = 1'b1;
      end
      KIND_ENABLE: begin
        disabled_o = 1'b0;
      end
      default: begin
        disabled_o = disabled_i;
      end
    endcase
  end

endmodule

FILE: design/generation_tagged_slot_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generation-tagged slot queue controller
// Hands out and retires slots of a bounded ring queue with generation tags.
// ----------------------------------------------------------------------------
// Throughput: one request per cycle while results are taken; the single
// slot-table read and write of each request, with forwarding between
// neighbours, sets that figure.
// Reset: pointers, counters and flags clear at once; the slot table is then
// swept to generation zero, empty, and no request is accepted during the
// sweep. Configuration writes are taken at any time.
// ----------------------------------------------------------------------------
module generation_tagged_slot_queue #(
  parameter int unsigned DEPTH    = 256,
  parameter int unsigned GEN_BITS = 30
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // Configuration write channel.
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [gtsq_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [gtsq_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  // Request stream.
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [39:0]                          s_axis_tdata,  // slot_generation, slot_index, zero pad
  input  logic [2:0]                           s_axis_tuser,  // kind
  // Result stream.
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  output logic [47:0]                          m_axis_tdata,  // granted_generation, granted_index,
                                                              // occupancy, is_enabled
  output logic [2:0]                           m_axis_tuser   // status
);
  import gtsq_pkg::*;

  localparam int unsigned IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned ENTRY_W = GEN_BITS + 2;
  localparam logic [GEN_FIELD_W-1:0] GEN_MASK = GEN_FIELD_W'((64'd1 << GEN_BITS) - 64'd1);

  // --------------------------------------------------------------------------
  // Configuration registers and their effective values.
  // --------------------------------------------------------------------------
  logic [CNT_W-1:0]       capacity_q;
  logic [GEN_FIELD_W-1:0] last_gen_q;
  logic [CNT_W-1:0]       eff_cap;
  logic [GEN_BITS-1:0]    eff_last;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q <= CAPACITY_RESET;
      last_gen_q <= LAST_GEN_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i == CFG_CAPACITY) begin
        capacity_q <= cfg_data_i[CNT_W-1:0];
      end else if (cfg_index_i == CFG_LAST_GEN) begin
        last_gen_q <= cfg_data_i;
      end
    end
  end

  // A capacity of zero behaves as one; anything above the built depth is
  // clipped to it. The last generation is clipped to the tag width.
  always_comb begin
    if (capacity_q == '0) begin
      eff_cap = CNT_W'(1);
    end else if (int'(capacity_q) > DEPTH) begin
      eff_cap = CNT_W'(DEPTH);
    end else begin
      eff_cap = capacity_q;
    end
  end

  assign eff_last = (last_gen_q > GEN_MASK) ? GEN_MASK[GEN_BITS-1:0]
                                            : last_gen_q[GEN_BITS-1:0];

  // --------------------------------------------------------------------------
  // Clearing sweep after reset.
  // --------------------------------------------------------------------------
  logic             clr_active_q;
  logic [IDX_W-1:0] clr_addr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_active_q <= 1'b1;
      clr_addr_q   <= '0;
    end else if (clr_active_q) begin
      if (clr_addr_q == IDX_W'(DEPTH - 1)) begin
        clr_active_q <= 1'b0;
      end
      clr_addr_q <= clr_addr_q + IDX_W'(1);
    end
  end

  // --------------------------------------------------------------------------
  // Execute stage: the accepted request waits here while its slot entry is
  // read. It retires into the result register when that register is free.
  // --------------------------------------------------------------------------
  logic                   x_valid_q;
  kind_e                  x_kind_q;
  logic [GEN_FIELD_W-1:0] x_gen_q;
  logic [IDX_FIELD_W-1:0] x_idx_q;
  logic [IDX_W-1:0]       x_addr_q;
  logic                   out_free;
  logic                   fire;
  logic                   accept;

  kind_e                  in_kind;
  logic [GEN_FIELD_W-1:0] in_gen;
  logic [IDX_FIELD_W-1:0] in_idx;

  assign in_kind = kind_e'(s_axis_tuser);
  assign in_gen  = s_axis_tdata[29:0];
  assign in_idx  = s_axis_tdata[37:30];

  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign fire          = x_valid_q && out_free;
  assign s_axis_tready = !clr_active_q && (!x_valid_q || out_free);
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Pointer and flag state.
  logic [GEN_BITS-1:0] push_gen_q, push_gen_d, push_gen_x;
  logic [IDX_W-1:0]    push_slot_q, push_slot_d, push_slot_x;
  logic [GEN_BITS-1:0] pop_gen_q, pop_gen_d, pop_gen_x;
  logic [IDX_W-1:0]    pop_slot_q, pop_slot_d, pop_slot_x;
  logic                disabled_q, disabled_d, disabled_x;
  logic [CNT_W-1:0]    count_q, count_d, count_x;
  logic                x_we;
  logic [ENTRY_W-1:0]  x_wdata;
  res_t                x_res;

  // Slot table and the forwarding of a write to the entry read right behind it.
  logic [ENTRY_W-1:0]  ram_rdata;
  logic [ENTRY_W-1:0]  entry;
  logic [IDX_W-1:0]    raddr;
  logic                ram_we;
  logic [IDX_W-1:0]    ram_waddr;
  logic [ENTRY_W-1:0]  ram_wdata;
  logic                fwd_q, fwd_d;
  logic [ENTRY_W-1:0]  fwd_data_q;

  assign entry = fwd_q ? fwd_data_q : ram_rdata;

  gtsq_exec #(
    .DEPTH   (DEPTH),
    .GEN_BITS(GEN_BITS)
  ) u_exec (
    .kind_i     (x_kind_q),
    .gen_i      (x_gen_q),
    .idx_i      (x_idx_q),
    .entry_i    (entry),
    .push_gen_i (push_gen_q),
    .push_slot_i(push_slot_q),
    .pop_gen_i  (pop_gen_q),
    .pop_slot_i (pop_slot_q),
    .disabled_i (disabled_q),
    .count_i    (count_q),
    .eff_cap_i  (eff_cap),
    .eff_last_i (eff_last),
    .push_gen_o (push_gen_x),
    .push_slot_o(push_slot_x),
    .pop_gen_o  (pop_gen_x),
    .pop_slot_o (pop_slot_x),
    .disabled_o (disabled_x),
    .count_o    (count_x),
    .we_o       (x_we),
    .wdata_o    (x_wdata),
    .res_o      (x_res)
  );

  // The state only moves when the execute stage retires a request.
  always_comb begin
    if (fire) begin
      push_gen_d  = push_gen_x;
      push_slot_d = push_slot_x;
      pop_gen_d   = pop_gen_x;
      pop_slot_d  = pop_slot_x;
      disabled_d  = disabled_x;
      count_d     = count_x;
    end else begin
      push_gen_d  = push_gen_q;
      push_slot_d = push_slot_q;
      pop_gen_d   = pop_gen_q;
      pop_slot_d  = pop_slot_q;
      disabled_d  = disabled_q;
      count_d     = count_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      push_gen_q  <= '0;
      push_slot_q <= '0;
      pop_gen_q   <= '0;
      pop_slot_q  <= '0;
      disabled_q  <= 1'b0;
      count_q     <= '0;
    end else begin
      push_gen_q  <= push_gen_d;
      push_slot_q <= push_slot_d;
      pop_gen_q   <= pop_gen_d;
      pop_slot_q  <= pop_slot_d;
      disabled_q  <= disabled_d;
      count_q     <= count_d;
    end
  end

  // Read address: a stalled request keeps re-reading its own entry. Otherwise
  // the incoming request looks at the pointers as they will stand after the
  // request now retiring, so back-to-back reserves see each other.
  always_comb begin
    if (x_valid_q && !out_free) begin
      raddr = x_addr_q;
    end else begin
      unique case (in_kind)
        KIND_RESERVE_PUSH: raddr = push_slot_d;
        KIND_RESERVE_POP,
        KIND_CLEAR_POP:    raddr = pop_slot_d;
        KIND_COMMIT_PUSH,
        KIND_COMMIT_POP,
        KIND_ABORT_PUSH,
        KIND_DISABLE,
        KIND_ENABLE:       raddr = IDX_W'(in_idx);
        default:           raddr = IDX_W'(in_idx);
      endcase
    end
  end

  // Every write of a request goes to the very entry that it read.
  always_comb begin
    if (clr_active_q) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr_q;
      ram_wdata = '0;
    end else begin
      ram_we    = fire && x_we;
      ram_waddr = x_addr_q;
      ram_wdata = x_wdata;
    end
  end

  // The RAM read and a write to the same entry meet at one edge; the written
  // value is carried alongside and takes the place of the stale read data.
  assign fwd_d = !clr_active_q && fire && x_we && (x_addr_q == raddr);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b0;
    end else begin
      fwd_q <= fwd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    fwd_data_q <= x_wdata;
  end

  gtsq_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(DEPTH)
  ) u_slot_table (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(raddr),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_valid_q <= 1'b0;
    end else if (accept) begin
      x_valid_q <= 1'b1;
    end else if (fire) begin
      x_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      x_kind_q <= in_kind;
      x_gen_q  <= in_gen;
      x_idx_q  <= in_idx;
      x_addr_q <= raddr;
    end
  end

  // --------------------------------------------------------------------------
  // Result register.
  // --------------------------------------------------------------------------
  logic        m_valid_q;
  logic [47:0] m_data_q;
  logic [2:0]  m_user_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (fire) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      m_user_q <= x_res.status;
      m_data_q <= {!disabled_x, count_x, x_res.gidx, x_res.ggen};
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Slot queue controller testbench
// Drives reserve, commit, abort, clear and enable requests into the slot queue
// controller and checks every result against a cycle-free behavioural copy of
// the controller kept here, under several capacity and generation settings.
// ----------------------------------------------------------------------------
module tb;
  import gtsq_pkg::*;

  // The spare index has no register behind it; a write there must be ignored.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd2;
  localparam int unsigned          DEPTH_N   = 256;

  // One expected result: the status travels on tuser, the rest on tdata.
  typedef struct packed {
    status_e                status;
    logic [GEN_FIELD_W-1:0] ggen;
    logic [IDX_FIELD_W-1:0] gidx;
    logic [CNT_W-1:0]       occ;
    logic                   en;
  } outcome_t;

  // A slot that this testbench currently holds for writing or reading.
  typedef struct {
    int unsigned gen;
    int unsigned idx;
  } slot_ref_t;

  logic                   clk_i;
  logic                   rst_ni        = 1'b0;
  logic                   cfg_valid_i   = 1'b0;
  logic                   cfg_ready_o;
  logic [CFG_IDX_W-1:0]   cfg_index_i   = '0;
  logic [CFG_DATA_W-1:0]  cfg_data_i    = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [39:0]            s_axis_tdata  = '0;  // slot_generation, slot_index, zero pad
  logic [2:0]             s_axis_tuser  = '0;  // kind
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [47:0]            m_axis_tdata;        // granted_generation, granted_index,
                                               // occupancy, is_enabled
  logic [2:0]             m_axis_tuser;        // status

  generation_tagged_slot_queue u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // --------------------------------------------------------------------------
  // Behavioural copy of the controller. It is advanced once per accepted
  // request, in request order, so it always reflects the state the block will
  // have once that request has been executed.
  // --------------------------------------------------------------------------
  logic [GEN_FIELD_W-1:0] tag_gen [DEPTH_N];
  slot_st_e               tag_st  [DEPTH_N];
  int unsigned            push_gen, push_idx, pop_gen, pop_idx, live_count;
  bit                     push_off;
  logic [CNT_W-1:0]       cap_reg;
  logic [GEN_FIELD_W-1:0] last_gen_reg;

  // Results still owed by the block, oldest first.
  outcome_t               grants_due [$];
  // Slots granted to us and not yet committed, so that most commits are valid.
  slot_ref_t              open_writes [$];
  slot_ref_t              open_reads [$];

  // Run control and statistics.
  int unsigned            idle_pct;
  int unsigned            stall_pct;
  int unsigned            hold_off_cycles;
  int unsigned            n_fail, n_sent, n_checked, n_settings;
  int unsigned            status_seen [7];

  // A capacity of zero behaves as one slot, anything above the built depth as
  // the whole depth.
  function automatic int unsigned live_capacity();
    if (cap_reg == 0) return 1;
    if (cap_reg > DEPTH_N) return DEPTH_N;
    return 32'(cap_reg);
  endfunction

  function automatic int unsigned gen_after(int unsigned g);
    return (g >= last_gen_reg) ? 0 : g + 1;
  endfunction

  // Pointers step through the slots and move to the next generation on wrap.
  function automatic void step_pointer(inout int unsigned gen, inout int unsigned idx);
    if (idx + 1 >= live_capacity()) begin
      idx = 0;
      gen = gen_after(gen);
    end else begin
      idx = idx + 1;
    end
  endfunction

  function automatic void count_in();
    if (live_count < live_capacity()) live_count++;
  endfunction

  // The count also clamps to the capacity, which may have been lowered.
  function automatic void count_out();
    if (live_count > 0) live_count--;
    if (live_count > live_capacity()) live_count = live_capacity();
  endfunction

  // Works out the result of one request and applies its effect on the state.
  function automatic outcome_t predict_grant(kind_e k, int unsigned g_in, int unsigned i_in);
    outcome_t    o;
    bit          args_ok;
    slot_st_e    need;
    int unsigned eg;
    slot_st_e    es;
    logic [7:0]  push_at, pop_at, req_at;
    o        = '0;
    o.status = STATUS_OK;
    args_ok  = (i_in < live_capacity()) && (g_in <= last_gen_reg);
    // Table positions as they stand before this request moves any pointer.
    push_at  = 8'(push_idx);
    pop_at   = 8'(pop_idx);
    req_at   = 8'(i_in);
    case (k)
      KIND_RESERVE_PUSH: begin
        eg = 32'(tag_gen[push_at]);
        es = tag_st[push_at];
        if (push_off) begin
          o.status = STATUS_DISABLED;
        end else if (eg == push_gen && es == SLOT_EMPTY) begin
          tag_st[push_at] = SLOT_WRITING;
          o.ggen = 30'(push_gen);
          o.gidx = 8'(push_idx);
          step_pointer(push_gen, push_idx);
          count_in();
        end else if (gen_after(eg) == push_gen && eg != push_gen) begin
          // Slot still held by the previous lap of the ring.
          o.status = (es == SLOT_READING) ? STATUS_BUSY : STATUS_FULL;
        end else begin
          step_pointer(push_gen, push_idx);
          count_in();
          o.status = STATUS_BUSY;
        end
      end
      KIND_COMMIT_PUSH, KIND_COMMIT_POP: begin
        need = (k == KIND_COMMIT_PUSH) ? SLOT_WRITING : SLOT_READING;
        if (!args_ok || tag_gen[req_at] != g_in || tag_st[req_at] != need) begin
          o.status = STATUS_MISMATCH;
        end else if (k == KIND_COMMIT_PUSH) begin
          tag_st[req_at] = SLOT_FULL;
        end else begin
          tag_gen[req_at] = 30'(gen_after(g_in));
          tag_st[req_at]  = SLOT_EMPTY;
        end
      end
      KIND_RESERVE_POP: begin
        eg = 32'(tag_gen[pop_at]);
        es = tag_st[pop_at];
        if (eg == pop_gen && es == SLOT_FULL) begin
          tag_st[pop_at] = SLOT_READING;
          o.ggen = 30'(pop_gen);
          o.gidx = 8'(pop_idx);
          step_pointer(pop_gen, pop_idx);
          count_out();
        end else if (eg != pop_gen && gen_after(eg) == pop_gen) begin
          o.status = STATUS_EMPTY;
        end else if (eg == pop_gen && es == SLOT_EMPTY) begin
          o.status = STATUS_EMPTY;
        end else if (eg != pop_gen || es == SLOT_WRITING) begin
          o.status = STATUS_BUSY;
        end else begin
          step_pointer(pop_gen, pop_idx);
          count_out();
          o.status = STATUS_BUSY;
        end
      end
      KIND_ABORT_PUSH: begin
        if (!args_ok || tag_gen[req_at] != g_in || tag_st[req_at] != SLOT_WRITING ||
            pop_gen != g_in || pop_idx != i_in) begin
          o.status = STATUS_MISMATCH;
        end else begin
          tag_gen[req_at] = 30'(gen_after(g_in));
          tag_st[req_at]  = SLOT_EMPTY;
          step_pointer(pop_gen, pop_idx);
          count_out();
        end
      end
      KIND_CLEAR_POP: begin
        if (!args_ok) begin
          o.status = STATUS_MISMATCH;
        end else if (pop_gen == g_in && pop_idx == i_in) begin
          o.status = STATUS_END;
        end else if (tag_gen[pop_at] == pop_gen && tag_st[pop_at] == SLOT_FULL) begin
          tag_st[pop_at] = SLOT_READING;
          o.ggen = 30'(pop_gen);
          o.gidx = 8'(pop_idx);
          step_pointer(pop_gen, pop_idx);
          count_out();
        end else if (tag_st[pop_at] == SLOT_WRITING || tag_st[pop_at] == SLOT_FULL) begin
          o.status = STATUS_BUSY;
        end else begin
          step_pointer(pop_gen, pop_idx);
          count_out();
          o.status = STATUS_BUSY;
        end
      end
      KIND_DISABLE: push_off = 1'b1;
      default:      push_off = 1'b0;
    endcase
    o.occ = 9'(live_count);
    o.en  = !push_off;
    return o;
  endfunction

  // --------------------------------------------------------------------------
  // Clock, time limit and result side.
  // --------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Far beyond the slowest legal run: about 700 requests with long gaps and
  // stalls, the reset sweep of the slot table and the long hold-off.
  initial begin
    #400000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // Result ready: random stalls, or a counted hold-off when a test asks.
  always @(posedge clk_i) begin
    if (hold_off_cycles != 0) begin
      hold_off_cycles--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  function automatic void note_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      n_fail++;
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
    end
  endfunction

  // Every accepted result is compared with the oldest outstanding expectation.
  always @(posedge clk_i) begin : check_results
    outcome_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (grants_due.size() == 0) begin
        n_fail++;
        $display("%0t: expected no result, got status %0d data %h", $time, m_axis_tuser,
                 m_axis_tdata);
      end else begin
        want = grants_due.pop_front();
        n_checked++;
        status_seen[want.status]++;
        note_field("status", 32'(want.status), 32'(m_axis_tuser));
        note_field("granted_generation", 32'(want.ggen), 32'(m_axis_tdata[29:0]));
        note_field("granted_index", 32'(want.gidx), 32'(m_axis_tdata[37:30]));
        note_field("occupancy", 32'(want.occ), 32'(m_axis_tdata[46:38]));
        note_field("is_enabled", 32'(want.en), 32'(m_axis_tdata[47]));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Request side.
  // --------------------------------------------------------------------------

  // Offers one request, with a random gap in front of it when the sender is
  // meant to idle, and records what the block owes once it is accepted.
  task automatic send_request(input kind_e k, input logic [29:0] g, input logic [7:0] i);
    outcome_t o;
    slot_ref_t sr;
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= k;
    s_axis_tdata  <= {2'b00, i, g};
    do @(posedge clk_i); while (!s_axis_tready);
    o = predict_grant(k, 32'(g), 32'(i));
    grants_due.push_back(o);
    n_sent++;
    // Keep track of the slots we now hold so later commits can name them.
    if (o.status == STATUS_OK) begin
      sr.gen = 32'(o.ggen);
      sr.idx = 32'(o.gidx);
      if (k == KIND_RESERVE_PUSH) open_writes.push_back(sr);
      else if (k == KIND_RESERVE_POP || k == KIND_CLEAR_POP) open_reads.push_back(sr);
    end
  endtask

  // Stops offering, waits for the last owed result and then lets the block settle.
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (grants_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // One register write; valid stays high so writes can follow back to back.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == CFG_CAPACITY) cap_reg = data[CNT_W-1:0];
    else if (idx == CFG_LAST_GEN) last_gen_reg = data;
  endtask

  // Only ever called with the block idle; pointers and slots carry over.
  task automatic configure(input int unsigned cap, input int unsigned last_gen);
    wait_idle();
    write_reg(CFG_CAPACITY, CFG_DATA_W'(cap));
    write_reg(CFG_LAST_GEN, CFG_DATA_W'(last_gen));
    cfg_valid_i <= 1'b0;
    n_settings++;
  endtask

  // Random traffic, mostly well-formed: reservations followed by commits of
  // the slots actually granted, with some corrupted commits, aborts, clears,
  // enable toggling and a share of completely random requests.
  task automatic run_mix(input int unsigned n_items, input int unsigned idle,
                         input int unsigned stall);
    int unsigned r, j;
    kind_e       k;
    logic [29:0] g;
    logic [7:0]  i;
    bit          found;
    idle_pct  = idle;
    stall_pct = stall;
    repeat (n_items) begin
      r = $urandom_range(99);
      g = 30'($urandom_range(last_gen_reg > 3 ? 3 : last_gen_reg));
      i = 8'($urandom_range(live_capacity() - 1));
      if (r < 24) begin
        k = KIND_RESERVE_PUSH;
      end else if (r < 40) begin
        k = KIND_COMMIT_PUSH;
        if (open_writes.size() != 0) begin
          j = $urandom_range(open_writes.size() - 1);
          g = 30'(open_writes[j].gen);
          i = 8'(open_writes[j].idx);
          if ($urandom_range(99) < 8) begin
            if ($urandom_range(1)) g ^= 30'(1) << $urandom_range(29);
            else i ^= 8'(1) << $urandom_range(7);
          end else begin
            open_writes.delete(j);
          end
        end
      end else if (r < 60) begin
        k = KIND_RESERVE_POP;
      end else if (r < 74) begin
        k = KIND_COMMIT_POP;
        if (open_reads.size() != 0) begin
          j = $urandom_range(open_reads.size() - 1);
          g = 30'(open_reads[j].gen);
          i = 8'(open_reads[j].idx);
          if ($urandom_range(99) < 8) begin
            if ($urandom_range(1)) g ^= 30'(1) << $urandom_range(29);
            else i ^= 8'(1) << $urandom_range(7);
          end else begin
            open_reads.delete(j);
          end
        end
      end else if (r < 79) begin
        // An abort only takes when the pop pointer sits on the held slot.
        k = KIND_ABORT_PUSH;
        found = 1'b0;
        foreach (open_writes[n]) begin
          if (!found && open_writes[n].gen == pop_gen && open_writes[n].idx == pop_idx) begin
            found = 1'b1;
            j = n;
          end
        end
        if (found) begin
          g = 30'(open_writes[j].gen);
          i = 8'(open_writes[j].idx);
          open_writes.delete(j);
        end else if (open_writes.size() != 0) begin
          g = 30'(open_writes[0].gen);
          i = 8'(open_writes[0].idx);
        end
      end else if (r < 85) begin
        k = KIND_CLEAR_POP;
        j = $urandom_range(3);
        if (j < 2) begin
          g = 30'(push_gen);
          i = 8'(push_idx);
        end else if (j == 2) begin
          g = 30'(pop_gen);
          i = 8'(pop_idx);
        end
      end else if (r < 87) begin
        k = KIND_DISABLE;
      end else if (r < 93) begin
        k = KIND_ENABLE;
      end else begin
        k = kind_e'($urandom_range(7));
        g = 30'($urandom());
        i = 8'($urandom_range(255));
      end
      send_request(k, g, i);
    end
  endtask

  // --------------------------------------------------------------------------
  // Tests.
  // --------------------------------------------------------------------------

  // Every operation and the main special cases at the reset settings.
  task automatic test_basic_ops();
    idle_pct  = 0;
    stall_pct = 0;
    send_request(KIND_RESERVE_POP, 30'd0, 8'd0);          // nothing to pop
    send_request(KIND_COMMIT_PUSH, 30'h3FFF_FFFF, 8'hFF); // generation out of range
    send_request(KIND_RESERVE_PUSH, 30'd0, 8'd0);
    send_request(KIND_RESERVE_PUSH, 30'd0, 8'd0);
    send_request(KIND_RESERVE_POP, 30'd0, 8'd0);          // slot still being written
    send_request(KIND_COMMIT_PUSH, 30'd0, 8'd0);
    send_request(KIND_COMMIT_PUSH, 30'd0, 8'd0);          // already committed
    send_request(KIND_RESERVE_POP, 30'd0, 8'd0);
    send_request(KIND_COMMIT_POP, 30'd0, 8'd0);
    send_request(KIND_COMMIT_POP, 30'd0, 8'd0);           // already retired
    send_request(KIND_ABORT_PUSH, 30'd0, 8'd1);           // pop pointer is on slot 1
    send_request(KIND_ABORT_PUSH, 30'd0, 8'd0);           // slot 0 is a newer lap
    send_request(KIND_DISABLE, 30'd0, 8'd0);
    send_request(KIND_RESERVE_PUSH, 30'd0, 8'd0);         // refused while disabled
    send_request(KIND_DISABLE, 30'd0, 8'd0);
    send_request(KIND_ENABLE, 30'd0, 8'd0);
    send_request(KIND_ENABLE, 30'h3FFF_FFFF, 8'hFF);
    send_request(KIND_CLEAR_POP, 30'd0, 8'd2);            // already at the end
    send_request(KIND_CLEAR_POP, 30'h3FFF_FFFF, 8'd2);    // bad end position
    send_request(KIND_RESERVE_PUSH, 30'd0, 8'd0);
    send_request(KIND_COMMIT_PUSH, 30'd0, 8'd2);
    send_request(KIND_CLEAR_POP, 30'd0, 8'd200);          // takes the full slot
    send_request(KIND_CLEAR_POP, 30'd0, 8'd200);          // skips an empty slot
    send_request(KIND_COMMIT_POP, 30'd0, 8'd2);
    send_request(KIND_COMMIT_PUSH, 30'd0, 8'hFF);         // slot never reserved
  endtask

  // A small ring with quick generation wrap, no idling on either side.
  task automatic test_tiny_ring();
    configure(4, 3);
    run_mix(150, 0, 0);
  endtask

  // Capacity written as zero behaves as a single slot; a single generation.
  task automatic test_single_slot();
    configure(0, 0);
    run_mix(100, 68, 0);
  endtask

  // Capacity above the depth, widest generation range, receiver stalling.
  task automatic test_full_depth();
    configure(511, 30'h3FFF_FFFF);
    run_mix(120, 0, 68);
  endtask

  // Capacity dropped under pointers left far out by the previous test; the
  // spare register index is written as well and must change nothing.
  task automatic test_shrunk_capacity();
    wait_idle();
    write_reg(CFG_SPARE, '1);
    configure(7, 2);
    run_mix(150, 27, 27);
  endtask

  // The receiver holds off long enough for the block to stop taking requests,
  // then the sender pauses until everything owed has come back.
  task automatic test_backpressure();
    configure(5, 1);
    hold_off_cycles = 120;
    run_mix(60, 0, 0);
    wait_idle();
    run_mix(60, 68, 68);
  endtask

  initial begin
    foreach (tag_gen[n]) begin
      tag_gen[n] = '0;
      tag_st[n]  = SLOT_EMPTY;
    end
    push_gen        = 0;
    push_idx        = 0;
    pop_gen         = 0;
    pop_idx         = 0;
    live_count      = 0;
    push_off        = 1'b0;
    cap_reg         = CAPACITY_RESET;
    last_gen_reg    = LAST_GEN_RESET;
    idle_pct        = 0;
    stall_pct       = 0;
    hold_off_cycles = 0;
    n_fail          = 0;
    n_sent          = 0;
    n_checked       = 0;
    n_settings      = 1;
    foreach (status_seen[n]) status_seen[n] = 0;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_basic_ops();
    test_tiny_ring();
    test_single_slot();
    test_full_depth();
    test_shrunk_capacity();
    test_backpressure();

    wait_idle();
    $display("Sent %0d requests over %0d queue settings; %0d results compared.",
             n_sent, n_settings, n_checked);
    $display("Statuses: ok %0d full %0d empty %0d disabled %0d busy %0d end %0d bad %0d.",
             status_seen[STATUS_OK], status_seen[STATUS_FULL], status_seen[STATUS_EMPTY],
             status_seen[STATUS_DISABLED], status_seen[STATUS_BUSY], status_seen[STATUS_END],
             status_seen[STATUS_MISMATCH]);
    if (n_fail == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
